FILE: rtl/rsc_pkg.sv
package rsc_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned MAX_DIGITS  = 32;
  localparam int unsigned DIGIT_ADDR_W = $clog2(MAX_DIGITS);
  localparam int unsigned COUNT_W     = $clog2(MAX_DIGITS + 1);

  localparam int unsigned BITS_PER_CYCLE = 4;
  localparam int unsigned DIV_CYCLES  = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
  localparam int unsigned DIV_W       = DIV_CYCLES * BITS_PER_CYCLE;
  localparam int unsigned DIV_CNT_W   = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  localparam int unsigned BASE_W      = 6;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned DIGIT_W     = 7;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned CFG_ADDR_W  = 1;

  localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_BASE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_BASE = 1'b1;

  localparam logic [BASE_W-1:0] SOURCE_BASE_RST = 6'd10;
  localparam logic [BASE_W-1:0] TARGET_BASE_RST = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MIN        = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX        = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'd57;
  localparam logic [CHAR_W-1:0] CHAR_SEVEN  = 8'd55;
  localparam logic [BASE_W-1:0] DECIMAL_TEN = 6'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STORE,
    ST_READ,
    ST_SHOW
  } rsc_state_e;

  typedef struct packed {
    logic accept;
    logic load;
    logic div_step;
    logic store;
    logic rd_en;
    logic pop;
  } rsc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic quot_zero;
    logic count_full;
    logic last_digit;
    logic out_done;
  } rsc_sts_t;

  function automatic logic [CHAR_W-1:0] char_value(input logic [CHAR_W-1:0] c);
    if (c <= CHAR_NINE) begin
      return c - CHAR_ZERO;
    end
    return c - CHAR_SEVEN;
  endfunction

  function automatic logic [DIGIT_W-1:0] ascii_of(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DECIMAL_TEN) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_SEVEN + CHAR_W'(d);
    end
    return c[DIGIT_W-1:0];
  endfunction

  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    if (b < BASE_MIN) begin
      return BASE_MIN;
    end
    if (b > BASE_MAX) begin
      return BASE_MAX;
    end
    return b;
  endfunction

endpackage

FILE: rtl/rsc_ctrl.sv
module rsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tlast,
  output logic              s_axis_tready,
  input  rsc_pkg::rsc_sts_t sts_i,
  output rsc_pkg::rsc_cmd_t cmd_o
);

  rsc_pkg::rsc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      rsc_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.accept = 1'b1;
          if (s_axis_tlast) begin
            cmd_o.load = 1'b1;
            state_d    = rsc_pkg::ST_DIV;
          end
        end
      end
      rsc_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = rsc_pkg::ST_STORE;
        end
      end
      rsc_pkg::ST_STORE: begin
        cmd_o.store = 1'b1;
        if (sts_i.quot_zero || sts_i.count_full) begin
          state_d = rsc_pkg::ST_READ;
        end else begin
          state_d = rsc_pkg::ST_DIV;
        end
      end
      rsc_pkg::ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = rsc_pkg::ST_SHOW;
      end
      rsc_pkg::ST_SHOW: begin
        if (sts_i.out_done) begin
          cmd_o.pop = 1'b1;
          state_d   = sts_i.last_digit ? rsc_pkg::ST_IDLE : rsc_pkg::ST_READ;
        end
      end
      default: begin
        state_d = rsc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/rsc_datapath.sv
module rsc_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rsc_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [rsc_pkg::BASE_W-1:0]          cfg_wdata_i,
  input  logic [rsc_pkg::CHAR_W-1:0]          char_code_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rsc_pkg::DIGIT_W-1:0]         digit_char_o,
  output logic                                is_last_digit_o,
  input  rsc_pkg::rsc_cmd_t                   cmd_i,
  output rsc_pkg::rsc_sts_t                   sts_o
);

  localparam int unsigned VW = rsc_pkg::VALUE_WIDTH;
  localparam int unsigned DW = rsc_pkg::DIV_W;
  localparam int unsigned BW = rsc_pkg::BASE_W;

  logic [BW-1:0]                    src_base_q, tgt_base_q;
  logic [VW-1:0]                    acc_q, acc_d;
  logic [DW-1:0]                    work_q, work_d;
  logic [BW-1:0]                    rem_q, rem_d;
  logic [rsc_pkg::DIV_CNT_W-1:0]    div_cnt_q;
  logic [rsc_pkg::COUNT_W-1:0]      count_q;
  logic                             out_valid_q;
  logic [rsc_pkg::DIGIT_W-1:0]      out_char_q;
  logic                             out_last_q;
  logic [BW-1:0]                    mem_q [rsc_pkg::MAX_DIGITS];
  logic [rsc_pkg::COUNT_W-1:0]      rd_idx;
  logic [BW-1:0]                    div_base;
  logic [VW-1:0]                    acc_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_base_q <= rsc_pkg::SOURCE_BASE_RST;
      tgt_base_q <= rsc_pkg::TARGET_BASE_RST;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == rsc_pkg::REG_SOURCE_BASE) begin
        src_base_q <= cfg_wdata_i;
      end else begin
        tgt_base_q <= cfg_wdata_i;
      end
    end
  end

  assign div_base = rsc_pkg::clamp_base(tgt_base_q);

  // Horner step: acc * base + digit, wrapping
  always_comb begin
    acc_next = VW'(acc_q * VW'(src_base_q)) + VW'(rsc_pkg::char_value(char_code_i));
    acc_d    = acc_q;
    if (cmd_i.accept) begin
      if (char_code_i >= rsc_pkg::CHAR_ZERO) begin
        acc_d = acc_next;
      end
    end
  end

  // Restoring division, several quotient bits a cycle
  always_comb begin
    logic [BW:0] r;
    r      = {1'b0, rem_q};
    work_d = work_q;
    for (int i = 0; i < rsc_pkg::BITS_PER_CYCLE; i++) begin
      r      = {r[BW-1:0], work_d[DW-1]};
      work_d = {work_d[DW-2:0], 1'b0};
      if (r >= {1'b0, div_base}) begin
        r         = r - {1'b0, div_base};
        work_d[0] = 1'b1;
      end
    end
    rem_d = r[BW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      div_cnt_q <= '0;
      count_q   <= '0;
      rem_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        acc_q <= '0;
      end else begin
        acc_q <= acc_d;
      end
      if (cmd_i.div_step) begin
        rem_q     <= rem_d;
        div_cnt_q <= div_cnt_q + 1'b1;
        if (sts_o.div_done) begin
          div_cnt_q <= '0;
        end
      end
      if (cmd_i.store) begin
        count_q <= count_q + 1'b1;
        rem_q   <= '0;
      end
      if (cmd_i.pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      work_q <= DW'(acc_d);
    end else if (cmd_i.div_step) begin
      work_q <= work_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem_q[count_q[rsc_pkg::DIGIT_ADDR_W-1:0]] <= rem_q;
    end
  end

  assign rd_idx = count_q - 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      out_char_q <= rsc_pkg::ascii_of(mem_q[rd_idx[rsc_pkg::DIGIT_ADDR_W-1:0]]);
      out_last_q <= sts_o.last_digit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.rd_en) begin
      out_valid_q <= 1'b1;
    end else if (sts_o.out_done) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign digit_char_o    = out_char_q;
  assign is_last_digit_o = out_last_q;

  assign sts_o.div_done   = (div_cnt_q == rsc_pkg::DIV_CNT_W'(rsc_pkg::DIV_CYCLES - 1));
  assign sts_o.quot_zero  = (work_q == '0);
  assign sts_o.count_full = (count_q == rsc_pkg::COUNT_W'(rsc_pkg::MAX_DIGITS - 1));
  assign sts_o.last_digit = (count_q == rsc_pkg::COUNT_W'(1));
  assign sts_o.out_done   = out_valid_q && out_ready_i;

endmodule

FILE: rtl/radix_string_converter.sv
// Radix converter for ASCII digit strings. Characters arrive one per item,
// most significant first, in the base held in register 0 (reset 10); each
// from '0' up is folded into a 32-bit wrapping value, and others leave it
// as it is. The item with tlast starts the conversion into the base of
// register 1 (reset 2, clamped to 2..36): the shared divider works out each
// output digit (4 quotient bits a cycle over 32 bits), and its remainder is
// then stored, at most 32 digits. Digits then leave most significant first,
// each held until m_axis_tready takes it before the next is read, with
// tlast on the final one; a zero value gives a single '0'. Input is held
// off from the last character until the final digit is taken. Write the
// base registers only while the block is idle.
module radix_string_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // is_last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] digit_char, [7] zero
  output logic        m_axis_tlast    // is_last_digit
);

  rsc_pkg::rsc_cmd_t cmd;
  rsc_pkg::rsc_sts_t sts;
  logic [rsc_pkg::DIGIT_W-1:0] digit_char;

  rsc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  rsc_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .char_code_i     (s_axis_tdata),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .digit_char_o    (digit_char),
    .is_last_digit_o (m_axis_tlast),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

  assign m_axis_tdata = {1'b0, digit_char};

endmodule

FILE: rtl/rsc_checker.sv
module rsc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a digit is pending");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata >= 8'd48 && m_axis_tdata <= 8'd57) ||
      (m_axis_tdata >= 8'd65 && m_axis_tdata <= 8'd90))
    else $error("digit character out of range");

  a_last_in_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input not held off after last character");

  a_last_out_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("digit shown after final digit");

endmodule

bind radix_string_converter rsc_checker u_rsc_checker (.*);

FILE: dv/radix_string_converter_tb.sv
module radix_string_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_PCT = 24;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS = 236;
  localparam int unsigned RADIX_DIGITS = 32;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam logic [7:0] ASCII_ALPHA_OFS = 8'h37;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_SLASH = 8'h2f;
  localparam logic [5:0] RADIX_FLOOR = 6'd2;
  localparam logic [5:0] RADIX_CEIL = 6'd36;

  typedef struct packed {
    logic [6:0] digit_char;
    logic       is_last_digit;
  } digit_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [0:0] cfg_addr_i = '0;
  logic [5:0] cfg_wdata_i = '0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // [7:0] char_code
  logic       s_axis_tlast = 1'b0; // is_last_char
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // [6:0] digit_char, [7] zero
  logic       m_axis_tlast;        // is_last_digit

  logic [31:0] value_acc;
  logic [5:0]  src_radix;
  logic [5:0]  dst_radix;
  digit_item_t pending_digits[$];
  int unsigned idle_pct = IDLE_PCT;
  int unsigned fail_count = 0;
  int unsigned stall_cycles = 0;

  radix_string_converter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [7:0] digit_code(input int unsigned d);
    if (d < 10) begin
      return ASCII_ZERO + 8'(d);
    end
    return ASCII_ALPHA_OFS + 8'(d);
  endfunction

  function automatic logic [5:0] pick_radix();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) begin
      return 6'($urandom_range(1, 0));
    end else if (r < 14) begin
      return 6'($urandom_range(63, 37));
    end
    return 6'($urandom_range(36, 2));
  endfunction

  // Fold one accepted character from '0' up into the value; on the last one, expand it.
  task automatic convert_char(input logic [7:0] c, input logic last);
    logic [7:0]  dval;
    logic [31:0] rest;
    logic [5:0]  radix;
    logic [5:0]  rems[RADIX_DIGITS];
    int          n;
    digit_item_t item;
    if (c >= ASCII_ZERO) begin
      dval = (c <= ASCII_NINE) ? c - ASCII_ZERO : c - ASCII_ALPHA_OFS;
      value_acc = value_acc * 32'(src_radix) + 32'(dval);
    end
    if (last) begin
      radix = dst_radix;
      if (radix < RADIX_FLOOR) radix = RADIX_FLOOR;
      if (radix > RADIX_CEIL) radix = RADIX_CEIL;
      rest = value_acc;
      n = 0;
      do begin
        rems[n] = 6'(rest % 32'(radix));
        rest = rest / 32'(radix);
        n++;
      end while (rest != 0 && n < RADIX_DIGITS);
      for (int k = n - 1; k >= 0; k--) begin
        item.digit_char = 7'(digit_code(rems[k]));
        item.is_last_digit = (k == 0);
        pending_digits = {pending_digits, item};
      end
      value_acc = '0;
    end
  endtask

  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    convert_char(c, last);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  // Hold off until every pending digit is out and the block has settled.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_digits.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [5:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == rsc_pkg::REG_SOURCE_BASE) src_radix = val;
    else dst_radix = val;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    send_text("255");
    send_text("0");
    send_char(ASCII_SLASH, 1'b1);
    send_char("1", 1'b0);
    send_char("2", 1'b0);
    send_char(ASCII_SPACE, 1'b1);
    wait_drain();
  endtask

  task automatic test_field_extremes();
    write_reg(rsc_pkg::REG_SOURCE_BASE, 6'd16);
    write_reg(rsc_pkg::REG_TARGET_BASE, 6'd2);
    send_text("FFFFFFFFF");
    wait_drain();
    write_reg(rsc_pkg::REG_TARGET_BASE, 6'd36);
    send_char(8'hff, 1'b0);
    send_char(8'h00, 1'b1);
    send_text("z");
    wait_drain();
  endtask

  task automatic test_odd_radices();
    write_reg(rsc_pkg::REG_SOURCE_BASE, 6'd0);
    write_reg(rsc_pkg::REG_TARGET_BASE, 6'd0);
    send_text("7");
    wait_drain();
    write_reg(rsc_pkg::REG_SOURCE_BASE, 6'd1);
    write_reg(rsc_pkg::REG_TARGET_BASE, 6'd63);
    send_text("35");
    wait_drain();
    write_reg(rsc_pkg::REG_SOURCE_BASE, 6'd63);
    write_reg(rsc_pkg::REG_TARGET_BASE, 6'd37);
    send_text("A1");
    wait_drain();
    write_reg(rsc_pkg::REG_SOURCE_BASE, 6'd36);
    write_reg(rsc_pkg::REG_TARGET_BASE, 6'd1);
    send_text("Z");
    wait_drain();
  endtask

  task automatic test_random_numbers();
    int unsigned sent;
    int unsigned len;
    int unsigned numbers;
    logic [7:0]  c;
    logic        last;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_pct = (sent >= 80 && sent < 150) ? 0 : IDLE_PCT;
      write_reg(rsc_pkg::REG_SOURCE_BASE, pick_radix());
      write_reg(rsc_pkg::REG_TARGET_BASE, pick_radix());
      numbers = $urandom_range(4, 1);
      repeat (numbers) begin
        len = ($urandom_range(9) == 0) ? 1 : $urandom_range(12, 1);
        for (int i = 0; i < len; i++) begin
          last = (i == len - 1);
          if ($urandom_range(99) < 12) begin
            c = 8'($urandom_range(255));
          end else if (last && $urandom_range(99) < 8) begin
            c = 8'($urandom_range(47));
          end else if (src_radix >= RADIX_FLOOR && src_radix <= RADIX_CEIL) begin
            c = digit_code($urandom_range(src_radix - 1, 0));
          end else begin
            c = digit_code($urandom_range(35, 0));
          end
          send_char(c, last);
          sent++;
        end
        if ($urandom_range(99) < 15) wait_drain();
      end
      wait_drain();
    end
    idle_pct = IDLE_PCT;
  endtask

  always @(posedge clk_i) begin
    digit_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_digits.size() == 0) begin
        $error("unexpected digit: got char %0d last %0b", m_axis_tdata[6:0], m_axis_tlast);
        fail_count++;
      end else begin
        want = pending_digits.pop_front();
        if (m_axis_tdata[6:0] !== want.digit_char) begin
          $error("digit_char: expected %0d, got %0d", want.digit_char, m_axis_tdata[6:0]);
          fail_count++;
        end
        if (m_axis_tdata[7] !== 1'b0) begin
          $error("tdata pad: expected 0, got %0b", m_axis_tdata[7]);
          fail_count++;
        end
        if (m_axis_tlast !== want.is_last_digit) begin
          $error("is_last_digit: expected %0b, got %0b", want.is_last_digit, m_axis_tlast);
          fail_count++;
        end
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    value_acc = '0;
    src_radix = rsc_pkg::SOURCE_BASE_RST;
    dst_radix = rsc_pkg::TARGET_BASE_RST;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_field_extremes();
    test_odd_radices();
    test_random_numbers();
    wait_drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
